// File: rtl/core/crc16_frame_checker_defines.svh
// Assertion macros used by the frame checker top level.
`ifndef CRC16_FRAME_CHECKER_DEFINES_SVH
`define CRC16_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CRCFC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define CRCFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/crcfc_pkg.sv
// Types, constants and codes of the CRC-16 frame checker.
`default_nettype none
package crcfc_pkg;

   localparam int unsigned HDR_BYTES = 14;

   localparam int unsigned POS_W = 17;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] PAYLOAD_START = POS_W'(HDR_BYTES + 2);
   localparam logic [POS_W-1:0] SHORT_LIMIT = POS_W'(HDR_BYTES - 1);

   localparam logic [POS_W-1:0] POS_HDR_ZERO_LAST = POS_W'(4);
   localparam logic [POS_W-1:0] POS_HDR_MARK_A = POS_W'(5);
   localparam logic [POS_W-1:0] POS_TYPE = POS_W'(6);
   localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(11);
   localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(12);
   localparam logic [POS_W-1:0] POS_HDR_MARK_B = POS_W'(13);
   localparam logic [POS_W-1:0] POS_CRC_START = POS_W'(4);

   localparam logic [7:0] HDR_MARK = 8'hFF;
   localparam logic [7:0] HDR_ZERO = 8'h00;

   localparam logic [15:0] CRC_POLY = 16'h1189;
   localparam logic [15:0] CRC_MSB = 16'h8000;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
   localparam logic [1:0] STATUS_BAD_HEADER = 2'd2;
   localparam logic [1:0] STATUS_BAD_CRC = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic       kind;
      logic [7:0] payload;
      logic [1:0] status;
      logic [7:0] mtype;
      logic       last;
   } result_type;

   // Up to two results per processed byte: first always fills before second.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage
`default_nettype wire

// File: rtl/core/crc16_frame_checker.sv
// Top level of the CRC-16 frame checker.
// Takes one frame byte per transfer with an end-of-frame mark and returns the
// payload bytes (header offset on, two bytes late) followed by one status
// result per frame: ok, bad length (also for short frames), bad header or
// bad CRC. Payload is only to be trusted when the frame's status is ok.
// A byte can enter in every cycle that input does not stall: it is registered,
// then the header checks and the unrolled eight-step CRC update run
// combinationally and write their results into an eight-entry result queue.
// The end-of-frame byte can add two results, so input stalls only while the
// queue lacks room for two more beyond the two a staged byte may add; with a
// consumer that never stalls the sustained rate is one byte per cycle.
`default_nettype none
`include "crc16_frame_checker_defines.svh"
module crc16_frame_checker
   import crcfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_frame,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_result_kind,
   output logic [7:0]      rsp_payload_byte,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_message_type,
   output logic            rsp_run_last
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_byte_ff;
   logic                  s1_eof_ff;
   logic                  req_take;
   push_type              push;
   result_type            head;
   logic [FIFO_CNT_W-1:0] fill;
   logic [FIFO_CNT_W:0]   committed;

   // hold input while the queue could not absorb two more results beyond the staged byte's two
   assign committed = (FIFO_CNT_W+1)'(fill) + (s1_valid_ff ? (FIFO_CNT_W+1)'(2) : '0);
   assign req_stall = committed > (FIFO_CNT_W+1)'(FIFO_DEPTH - 2);
   assign req_take  = req_valid & ~req_stall;
   assign s1_valid_in = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
         s1_eof_ff  <= req_end_of_frame;
      end
   end

   crcfc_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item_byte  (s1_byte_ff),
      .item_eof   (s1_eof_ff),
      .push       (push)
   );

   crcfc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (~rsp_stall),
      .head_valid (rsp_valid),
      .head       (head),
      .fill       (fill)
   );

   assign rsp_result_kind  = head.kind;
   assign rsp_payload_byte = head.payload;
   assign rsp_status       = head.status;
   assign rsp_message_type = head.mtype;
   assign rsp_run_last     = head.last;

   `CRCFC_ASSERT_NEXT(a_take_loads_stage, clock, reset, req_take, s1_valid_ff, "accepted byte not staged")
   `CRCFC_ASSERT_IMPL(a_room_for_stage, clock, reset, s1_valid_ff, fill <= FIFO_CNT_W'(FIFO_DEPTH - 2), "queue lacks room for staged byte")
   `CRCFC_ASSERT_IMPL(a_status_is_last, clock, reset, rsp_valid && rsp_result_kind == KIND_STATUS, rsp_run_last && rsp_payload_byte == 8'h00, "status result malformed")
   `CRCFC_ASSERT_IMPL(a_payload_clean, clock, reset, rsp_valid && rsp_result_kind == KIND_PAYLOAD, rsp_status == STATUS_OK && rsp_message_type == 8'h00, "payload result malformed")

endmodule
`default_nettype wire

// File: rtl/core/crcfc_crc.sv
// One-byte MSB-first CRC-16 update, unrolled over the eight bits.
`default_nettype none
module crcfc_crc
   import crcfc_pkg::*;
(
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data_byte,
   output logic [15:0]      crc_next
);

   always_comb begin
      logic [15:0] v;
      v = crc_cur ^ {data_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((v & CRC_MSB) != 16'h0000) begin
            v = {v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      crc_next = v;
   end

endmodule
`default_nettype wire

// File: rtl/core/crcfc_frame.sv
// Per-frame state: header checks, length capture, CRC and result forming.
`default_nettype none
module crcfc_frame
   import crcfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire logic [7:0] item_byte,
   input  wire logic       item_eof,
   output push_type        push
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       dly_ff [3];
   logic [7:0]       dly_in [3];
   logic             hdr_bad_ff, hdr_bad_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       type_ff, type_in;

   logic [15:0]      crc_step;
   logic [15:0]      crc_upd;
   logic             hdr_bad_upd;
   logic [15:0]      len_upd;
   logic [7:0]       type_upd;
   logic             has_payload;
   logic [POS_W:0]   len_expect;
   logic [1:0]       status;
   result_type       pay_res;
   result_type       stat_res;

   crcfc_crc u_crc (
      .crc_cur   (crc_ff),
      .data_byte (dly_ff[2]),
      .crc_next  (crc_step)
   );

   always_comb begin
      hdr_bad_upd = hdr_bad_ff;
      if (pos_ff <= POS_HDR_ZERO_LAST) begin
         if (item_byte != HDR_ZERO) hdr_bad_upd = 1'b1;
      end else if (pos_ff == POS_HDR_MARK_A || pos_ff == POS_HDR_MARK_B) begin
         if (item_byte != HDR_MARK) hdr_bad_upd = 1'b1;
      end

      type_upd = (pos_ff == POS_TYPE) ? item_byte : type_ff;

      len_upd = len_ff;
      if (pos_ff == POS_LEN_HI) len_upd = {item_byte, len_ff[7:0]};
      if (pos_ff == POS_LEN_LO) len_upd = {len_ff[15:8], item_byte};

      crc_upd = (pos_ff >= POS_CRC_START) ? crc_step : crc_ff;

      has_payload = pos_ff >= PAYLOAD_START;

      // size - HDR_BYTES + 1, with size = position + 1
      len_expect = {1'b0, pos_ff} + (POS_W+1)'(2) - (POS_W+1)'(HDR_BYTES);

      priority if (pos_ff < SHORT_LIMIT) begin
         status = STATUS_BAD_LENGTH;
      end else if (hdr_bad_upd) begin
         status = STATUS_BAD_HEADER;
      end else if (len_expect != (POS_W+1)'(len_upd)) begin
         status = STATUS_BAD_LENGTH;
      end else if ({dly_ff[0], item_byte} != crc_upd) begin
         status = STATUS_BAD_CRC;
      end else begin
         status = STATUS_OK;
      end

      pay_res.kind    = KIND_PAYLOAD;
      pay_res.payload = dly_ff[1];
      pay_res.status  = STATUS_OK;
      pay_res.mtype   = 8'h00;
      pay_res.last    = ~item_eof;

      stat_res.kind    = KIND_STATUS;
      stat_res.payload = 8'h00;
      stat_res.status  = status;
      stat_res.mtype   = type_upd;
      stat_res.last    = 1'b1;

      push.count  = 2'd0;
      push.first  = pay_res;
      push.second = stat_res;
      if (item_valid) begin
         unique case ({has_payload, item_eof})
            2'b00: push.count = 2'd0;
            2'b10: push.count = 2'd1;
            2'b01: begin
               push.count = 2'd1;
               push.first = stat_res;
            end
            2'b11: push.count = 2'd2;
            default: push.count = 2'd0;
         endcase
      end

      pos_in     = pos_ff;
      crc_in     = crc_ff;
      dly_in     = dly_ff;
      hdr_bad_in = hdr_bad_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      if (item_valid) begin
         if (item_eof) begin
            // clear for the next frame
            pos_in     = '0;
            crc_in     = CRC_INIT;
            dly_in[0]  = 8'h00;
            dly_in[1]  = 8'h00;
            dly_in[2]  = 8'h00;
            hdr_bad_in = 1'b0;
            len_in     = 16'h0000;
            type_in    = 8'h00;
         end else begin
            pos_in     = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
            crc_in     = crc_upd;
            dly_in[2]  = dly_ff[1];
            dly_in[1]  = dly_ff[0];
            dly_in[0]  = item_byte;
            hdr_bad_in = hdr_bad_upd;
            len_in     = len_upd;
            type_in    = type_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= CRC_INIT;
         dly_ff[0]  <= 8'h00;
         dly_ff[1]  <= 8'h00;
         dly_ff[2]  <= 8'h00;
         hdr_bad_ff <= 1'b0;
         len_ff     <= 16'h0000;
         type_ff    <= 8'h00;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         dly_ff     <= dly_in;
         hdr_bad_ff <= hdr_bad_in;
         len_ff     <= len_in;
         type_ff    <= type_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/crcfc_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
`default_nettype none
module crcfc_fifo
   import crcfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire push_type          push,
   input  wire logic              pop,
   output logic                   head_valid,
   output result_type             head,
   output logic [FIFO_CNT_W-1:0]  fill
);

   result_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_nx;
   logic                    do_pop;

   assign head_valid = cnt_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign fill       = cnt_ff;
   assign do_pop     = pop & head_valid;
   assign wr_ptr_nx  = wr_ptr_ff + FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem_ff[wr_ptr_nx] <= push.second;
   end

endmodule
`default_nettype wire

// File: bench/crc16_frame_checker_tb.sv
// Self-checking testbench of the CRC-16 frame checker with a built-in frame predictor.
`timescale 1ns / 100ps
module crc16_frame_checker_tb
   import crcfc_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int DIRECTED_ROWS = 26;
   localparam int PHASE_BYTES = 130;

   typedef enum logic [1:0] {FILL_NONE, FILL_CRC_HI, FILL_CRC_LO} crc_fill_type;

   typedef struct packed {
      logic [7:0]   data;
      logic         eof;
      crc_fill_type fill;
      logic         typed;
      logic [1:0]   want_status;
      logic [7:0]   want_type;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_end_of_frame;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_result_kind;
   logic [7:0] rsp_payload_byte;
   logic [1:0] rsp_status;
   logic [7:0] rsp_message_type;
   logic       rsp_run_last;

   // predictor state
   logic [POS_W-1:0] frame_pos;
   logic [15:0]      crc_acc;
   logic [7:0]       recent [3];
   logic             hdr_bad;
   logic [15:0]      len_field;
   logic [7:0]       type_seen;
   result_type       predicted_results [$];

   logic [7:0]  frame_bytes [$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned results_checked = 0;
   int unsigned status_seen [4] = '{0, 0, 0, 0};
   int unsigned cycle_count = 0;

   // one frame of each flavor: too short before the type byte, well formed with
   // payload extremes, short with a captured type and a bad header byte
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{8'hFF, 1'b1, FILL_NONE,   1'b1, STATUS_BAD_LENGTH, 8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h01, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h80, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h7F, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'hFE, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h05, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_CRC_HI, 1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b1, FILL_CRC_LO, 1'b1, STATUS_OK,         8'hFF},
      '{8'h01, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h00, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'hFF, 1'b0, FILL_NONE,   1'b0, STATUS_OK,         8'h00},
      '{8'h5A, 1'b1, FILL_NONE,   1'b1, STATUS_BAD_LENGTH, 8'h5A}
   };

   crc16_frame_checker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_status       (rsp_status),
      .rsp_message_type (rsp_message_type),
      .rsp_run_last     (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
      logic [15:0] v;
      v = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
         v = (v & CRC_MSB) ? ((v << 1) ^ CRC_POLY) : (v << 1);
      return v;
   endfunction

   // CRC of the frame being built: bytes 1 to size-4
   function automatic logic [15:0] frame_crc(int size);
      logic [15:0] c;
      c = CRC_INIT;
      for (int k = 1; k <= size - 4; k++)
         c = crc16_update(c, frame_bytes[k]);
      return c;
   endfunction

   function automatic void clear_frame_state();
      frame_pos = '0;
      crc_acc = CRC_INIT;
      recent = '{8'h00, 8'h00, 8'h00};
      hdr_bad = 1'b0;
      len_field = '0;
      type_seen = '0;
   endfunction

   function automatic void predict_frame_byte(logic [7:0] b, logic eof, logic fixed,
                                              logic [1:0] fixed_status, logic [7:0] fixed_type);
      logic [POS_W-1:0] p;
      logic [1:0]       st;
      int unsigned      size_now;
      p = frame_pos;
      if (p <= POS_HDR_ZERO_LAST) begin
         if (b != HDR_ZERO) hdr_bad = 1'b1;
      end else if (p == POS_HDR_MARK_A || p == POS_HDR_MARK_B) begin
         if (b != HDR_MARK) hdr_bad = 1'b1;
      end
      if (p == POS_TYPE) type_seen = b;
      if (p == POS_LEN_HI) len_field[15:8] = b;
      if (p == POS_LEN_LO) len_field[7:0] = b;
      // the CRC trails the input by three bytes, the payload by two
      if (p >= POS_CRC_START) crc_acc = crc16_update(crc_acc, recent[2]);
      if (p >= PAYLOAD_START)
         predicted_results.push_back('{KIND_PAYLOAD, recent[1], STATUS_OK, 8'h00, ~eof});
      if (eof) begin
         size_now = p + 1;
         if (size_now < HDR_BYTES) st = STATUS_BAD_LENGTH;
         else if (hdr_bad) st = STATUS_BAD_HEADER;
         else if (size_now - HDR_BYTES + 1 != {16'h0000, len_field}) st = STATUS_BAD_LENGTH;
         else if ({recent[0], b} == crc_acc) st = STATUS_OK;
         else st = STATUS_BAD_CRC;
         if (fixed)
            predicted_results.push_back('{KIND_STATUS, 8'h00, fixed_status, fixed_type, 1'b1});
         else
            predicted_results.push_back('{KIND_STATUS, 8'h00, st, type_seen, 1'b1});
         clear_frame_state();
      end else begin
         recent[2] = recent[1];
         recent[1] = recent[0];
         recent[0] = b;
         if (p < POS_MAX) frame_pos = p + POS_W'(1);
      end
   endfunction

   task automatic log_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      error_count++;
   endtask

   // hold the byte until the transfer completes, then predict its results
   task automatic send_byte(input logic [7:0] b, input logic eof, input logic fixed,
                            input logic [1:0] fixed_status, input logic [7:0] fixed_type);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_frame <= eof;
      forever begin
         @(posedge clock);
         if (req_stall === 1'b0) break;
      end
      predict_frame_byte(b, eof, fixed, fixed_status, fixed_type);
      bytes_sent++;
   endtask

   function automatic logic [7:0] header_byte(int pos, int size, logic [7:0] mtype);
      logic [15:0] len;
      len = 16'(size - HDR_BYTES + 1);
      if (pos <= POS_HDR_ZERO_LAST) return HDR_ZERO;
      if (pos == POS_HDR_MARK_A || pos == POS_HDR_MARK_B) return HDR_MARK;
      if (pos == POS_TYPE) return mtype;
      if (pos == POS_LEN_HI) return len[15:8];
      if (pos == POS_LEN_LO) return len[7:0];
      return 8'($urandom);
   endfunction

   function automatic void spoil_byte(int pos);
      frame_bytes[pos] = frame_bytes[pos] ^ (8'd1 << $urandom_range(7));
   endfunction

   task automatic send_random_frame();
      int          size;
      int          roll;
      int          pos;
      logic [7:0]  mtype;
      logic [15:0] crc;
      roll = $urandom_range(99);
      mtype = 8'($urandom);
      if (roll < 14) size = $urandom_range(1, HDR_BYTES + 1);
      else if (roll < 22) size = $urandom_range(1, 48);
      else if ($urandom_range(9) == 0) size = HDR_BYTES + 2 + $urandom_range(7, 60);
      else size = HDR_BYTES + 2 + $urandom_range(0, 6);
      frame_bytes.delete();
      for (int k = 0; k < size; k++)
         frame_bytes.push_back(header_byte(k, size, mtype));
      if (size >= HDR_BYTES + 2) begin
         crc = frame_crc(size);
         frame_bytes[size-2] = crc[15:8];
         frame_bytes[size-1] = crc[7:0];
      end
      if (roll < 14) begin
         if ($urandom_range(3) == 0) spoil_byte($urandom_range(0, size - 1));
      end else if (roll < 22) begin
         for (int k = 0; k < size; k++)
            if ($urandom_range(1) == 1) frame_bytes[k] = 8'($urandom);
      end else begin
         // corrupt header, length and CRC independently so priorities overlap
         if ($urandom_range(99) < 15) begin
            pos = $urandom_range(0, 6);
            spoil_byte(pos == 6 ? 13 : pos);
         end
         if ($urandom_range(99) < 15) spoil_byte($urandom_range(11, 12));
         if ($urandom_range(99) < 15) begin
            pos = $urandom_range(7, size - 1);
            if (pos >= 11 && pos <= 13) pos -= 4;
            spoil_byte(pos);
         end
      end
      for (int k = 0; k < size; k++)
         send_byte(frame_bytes[k], k == size - 1, 1'b0, STATUS_OK, 8'h00);
      frames_sent++;
   endtask

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{rsp_result_kind, rsp_payload_byte, rsp_status, rsp_message_type, rsp_run_last};
         results_checked++;
         if (predicted_results.size() == 0) begin
            log_mismatch($sformatf("result %0d arrived with nothing pending: %h",
                                   results_checked, got));
         end else begin
            want = predicted_results.pop_front();
            if (got.kind !== want.kind)
               log_mismatch($sformatf("result %0d kind %b, want %b",
                                      results_checked, got.kind, want.kind));
            if (got.payload !== want.payload)
               log_mismatch($sformatf("result %0d payload %h, want %h",
                                      results_checked, got.payload, want.payload));
            if (got.status !== want.status)
               log_mismatch($sformatf("result %0d status %0d, want %0d",
                                      results_checked, got.status, want.status));
            if (got.mtype !== want.mtype)
               log_mismatch($sformatf("result %0d message type %h, want %h",
                                      results_checked, got.mtype, want.mtype));
            if (got.last !== want.last)
               log_mismatch($sformatf("result %0d run_last %b, want %b",
                                      results_checked, got.last, want.last));
            if (want.kind == KIND_STATUS) status_seen[want.status]++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, predicted_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      logic [7:0]   b;
      logic [15:0]  crc;
      int           i;
      int           phase;
      int unsigned  phase_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_end_of_frame = 1'b0;
      send_idle_pct = 35;
      recv_idle_pct = 61;
      clear_frame_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      frame_bytes.delete();
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         b = row.data;
         if (row.fill == FILL_CRC_HI) begin
            crc = frame_crc(frame_bytes.size() + 2);
            b = crc[15:8];
         end else if (row.fill == FILL_CRC_LO) begin
            crc = frame_crc(frame_bytes.size() + 1);
            b = crc[7:0];
         end
         frame_bytes.push_back(b);
         send_byte(b, row.eof, row.typed, row.want_status, row.want_type);
         if (row.eof) begin
            frame_bytes.delete();
            frames_sent++;
         end
      end

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 61 : 0;
         recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 35 : 0;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES)
            send_random_frame();
      end
      req_valid <= 1'b0;

      while (predicted_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("%0d frames, %0d bytes in under three stall mixes, %0d results checked",
               frames_sent, bytes_sent, results_checked);
      $display("frame status: %0d ok, %0d bad length, %0d bad header, %0d bad crc",
               status_seen[STATUS_OK], status_seen[STATUS_BAD_LENGTH],
               status_seen[STATUS_BAD_HEADER], status_seen[STATUS_BAD_CRC]);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/crcfc_pkg.sv
rtl/core/crcfc_crc.sv
rtl/core/crcfc_frame.sv
rtl/core/crcfc_fifo.sv
rtl/core/crc16_frame_checker.sv
bench/crc16_frame_checker_tb.sv
